// ===== src/assert_macros.svh =====
// Assertion macros shared by the barycentric weight unit RTL.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BWU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BWU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BWU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BWU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/bwu_pkg.sv =====
// Widths, register indexes and output codes of the barycentric weight unit.
// No dependencies.
package bwu_pkg;
	localparam int COORD_WIDTH     = 16;
	localparam int COORD_FRAC_BITS = 4;
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int NUM_W   = CROSS_W + 2;
	localparam int DEN_W   = CROSS_W;
	localparam int W_W     = 32;
	localparam int W_FRAC  = 16;
	localparam int QUO_W   = W_W + 1;
	localparam int INT_SH  = QUO_W - W_FRAC;
	localparam int REM_W   = DEN_W + 1;
	localparam int CMP_W   = DEN_W + INT_SH;
	localparam int DIV_LAT = QUO_W + 1;
	localparam int IDX_W   = 3;
	localparam int DEG_UNIT = 1 << (2 * COORD_FRAC_BITS);

	localparam logic [IDX_W-1:0] REG_AX = 3'd0;
	localparam logic [IDX_W-1:0] REG_AY = 3'd1;
	localparam logic [IDX_W-1:0] REG_BX = 3'd2;
	localparam logic [IDX_W-1:0] REG_BY = 3'd3;
	localparam logic [IDX_W-1:0] REG_CX = 3'd4;
	localparam logic [IDX_W-1:0] REG_CY = 3'd5;

	localparam logic [W_W-1:0] W_MAX     = 32'h7FFF_FFFF;
	localparam logic [W_W-1:0] W_MIN     = 32'h8000_0000;
	localparam logic [W_W-1:0] W_NEG_ONE = 32'hFFFF_0000;
endpackage

// ===== src/bwu_div_lane.sv =====
// Pipelined restoring divider: magnitude quotient (num << 16) / den, one bit per stage.
// Depends on bwu_pkg.
module bwu_div_lane (
	input  logic                        clk,
	input  logic [bwu_pkg::NUM_W-1:0]   num,
	input  logic [bwu_pkg::DEN_W-1:0]   den,
	output logic [bwu_pkg::QUO_W-1:0]   quo,
	output logic                        ovf
);
	logic [bwu_pkg::REM_W-1:0] rem_s [0:bwu_pkg::QUO_W];
	logic [bwu_pkg::QUO_W-1:0] lo_s  [0:bwu_pkg::QUO_W];
	logic [bwu_pkg::QUO_W-1:0] q_s   [0:bwu_pkg::QUO_W];
	logic [bwu_pkg::DEN_W-1:0] den_s [0:bwu_pkg::QUO_W];
	logic                      ovf_s [0:bwu_pkg::QUO_W];

	// quotient must stay below 2^QUO_W, else ovf is raised for the caller to saturate
	always_ff @(posedge clk) begin
		ovf_s[0] <= bwu_pkg::CMP_W'(num) >= {den, {bwu_pkg::INT_SH{1'b0}}};
		rem_s[0] <= bwu_pkg::REM_W'(num >> bwu_pkg::INT_SH);
		lo_s[0]  <= {num[bwu_pkg::INT_SH-1:0], {bwu_pkg::W_FRAC{1'b0}}};
		q_s[0]   <= '0;
		den_s[0] <= den;
	end

	for (genvar k = 1; k <= bwu_pkg::QUO_W; k++) begin : g_step
		logic [bwu_pkg::REM_W-1:0] trial;
		logic                      fits;
		assign trial = {rem_s[k-1][bwu_pkg::REM_W-2:0], lo_s[k-1][bwu_pkg::QUO_W-1]};
		assign fits  = trial >= bwu_pkg::REM_W'(den_s[k-1]);
		always_ff @(posedge clk) begin
			rem_s[k] <= fits ? trial - bwu_pkg::REM_W'(den_s[k-1]) : trial;
			lo_s[k]  <= lo_s[k-1] << 1;
			q_s[k]   <= {q_s[k-1][bwu_pkg::QUO_W-2:0], fits};
			den_s[k] <= den_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
		end
	end

	assign quo = q_s[bwu_pkg::QUO_W];
	assign ovf = ovf_s[bwu_pkg::QUO_W];
endmodule

// ===== src/barycentric_weight_unit_core.sv =====
// Top level of the barycentric weight unit: edge set-up, cross products, dividers.
// Depends on bwu_pkg, bwu_div_lane and assert_macros.svh.
//
// channel   direction  handshake            beat
// config    in         cfg_we               cfg_idx, cfg_wdata
// pixel     in         start && !busy       pixel_x, pixel_y
// weights   out        done (one cycle)     weight_a/b/c, degenerate
//
// Between the edge that takes a pixel and the edge that takes its weights lie these
// register stages: point offsets, products, cross terms, numerators, magnitudes (5),
// the divider lanes at one quotient bit per stage after a set-up stage (34) and the
// saturating output register (1). One pixel per clock is sustained; busy is never raised.
// arst_n clears the vertex registers and every valid bit; data stages hold no reset.
// Results cannot be stalled: each weight beat shows for exactly one cycle.
`include "assert_macros.svh"
module barycentric_weight_unit_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bwu_pkg::IDX_W-1:0]             cfg_idx,
	input  logic [bwu_pkg::COORD_WIDTH-1:0]       cfg_wdata,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [bwu_pkg::COORD_WIDTH-1:0] pixel_x,
	input  logic signed [bwu_pkg::COORD_WIDTH-1:0] pixel_y,
	output logic                                  done,
	output logic signed [bwu_pkg::W_W-1:0]        weight_a,
	output logic signed [bwu_pkg::W_W-1:0]        weight_b,
	output logic signed [bwu_pkg::W_W-1:0]        weight_c,
	output logic                                  degenerate
);
	localparam int CW = bwu_pkg::COORD_WIDTH;
	localparam int DW = bwu_pkg::DIFF_W;
	localparam int PW = bwu_pkg::PROD_W;
	localparam int XW = bwu_pkg::CROSS_W;
	localparam int NW = bwu_pkg::NUM_W;
	localparam int LAT = bwu_pkg::DIV_LAT;

	// vertex registers; the user must write them only while the pipe is empty, the block does not enforce it
	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0; ay_q <= '0; bx_q <= '0;
			by_q <= '0; cx_q <= '0; cy_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				bwu_pkg::REG_AX: ax_q <= cfg_wdata;
				bwu_pkg::REG_AY: ay_q <= cfg_wdata;
				bwu_pkg::REG_BX: bx_q <= cfg_wdata;
				bwu_pkg::REG_BY: by_q <= cfg_wdata;
				bwu_pkg::REG_CX: cx_q <= cfg_wdata;
				bwu_pkg::REG_CY: cy_q <= cfg_wdata;
				default: ; // drop writes beyond the last vertex register
			endcase
		end
	end

	// edge vectors follow the configuration directly
	logic signed [DW-1:0] e0x, e0y, e1x, e1y;
	assign e0x = DW'(cx_q) - DW'(ax_q);
	assign e0y = DW'(cy_q) - DW'(ay_q);
	assign e1x = DW'(bx_q) - DW'(ax_q);
	assign e1y = DW'(by_q) - DW'(ay_q);

	assign busy = 1'b0;
	logic acc;
	assign acc = start && !busy;

	// valid bits, one per stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_out_q;
	logic v_d_s [0:LAT-1];

	// stage 1: point offsets from vertex A
	logic signed [DW-1:0] dx_s1, dy_s1;
	always_ff @(posedge clk) begin
		dx_s1 <= DW'(ax_q) - DW'(pixel_x);
		dy_s1 <= DW'(ay_q) - DW'(pixel_y);
	end

	// stage 2: six products
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	always_ff @(posedge clk) begin
		p1_s2 <= PW'(e1x) * PW'(dy_s1);
		p2_s2 <= PW'(dx_s1) * PW'(e1y);
		p3_s2 <= PW'(dx_s1) * PW'(e0y);
		p4_s2 <= PW'(e0x) * PW'(dy_s1);
		p5_s2 <= PW'(e0x) * PW'(e1y);
		p6_s2 <= PW'(e1x) * PW'(e0y);
	end

	// stage 3: cross terms
	logic signed [XW-1:0] ux_s3, uy_s3, uz_s3;
	always_ff @(posedge clk) begin
		ux_s3 <= XW'(p1_s2) - XW'(p2_s2);
		uy_s3 <= XW'(p3_s2) - XW'(p4_s2);
		uz_s3 <= XW'(p5_s2) - XW'(p6_s2);
	end

	// stage 4: numerators and the small-area test
	logic signed [NW-1:0] na_s4, nb_s4, nc_s4;
	logic signed [XW-1:0] uz_s4;
	logic                 deg_s4;
	always_ff @(posedge clk) begin
		na_s4  <= NW'(uz_s3) - NW'(ux_s3) - NW'(uy_s3);
		nb_s4  <= NW'(uy_s3);
		nc_s4  <= NW'(ux_s3);
		uz_s4  <= uz_s3;
		deg_s4 <= (uz_s3 < XW'(bwu_pkg::DEG_UNIT)) && (uz_s3 > -XW'(bwu_pkg::DEG_UNIT));
	end

	// stage 5: magnitudes and quotient signs
	logic [NW-1:0]                 ua_s5, ub_s5, uc_s5;
	logic [bwu_pkg::DEN_W-1:0]     ud_s5;
	logic                          nga_s5, ngb_s5, ngc_s5, deg_s5;
	always_ff @(posedge clk) begin
		ua_s5  <= na_s4[NW-1] ? NW'(-na_s4) : NW'(na_s4);
		ub_s5  <= nb_s4[NW-1] ? NW'(-nb_s4) : NW'(nb_s4);
		uc_s5  <= nc_s4[NW-1] ? NW'(-nc_s4) : NW'(nc_s4);
		ud_s5  <= uz_s4[XW-1] ? bwu_pkg::DEN_W'(-uz_s4) : bwu_pkg::DEN_W'(uz_s4);
		nga_s5 <= na_s4[NW-1] ^ uz_s4[XW-1];
		ngb_s5 <= nb_s4[NW-1] ^ uz_s4[XW-1];
		ngc_s5 <= nc_s4[NW-1] ^ uz_s4[XW-1];
		deg_s5 <= deg_s4;
	end

	// three divider lanes of LAT stages each
	logic [bwu_pkg::QUO_W-1:0] qa, qb, qc;
	logic                      oa, ob, oc;
	bwu_div_lane u_div_a (.clk(clk), .num(ua_s5), .den(ud_s5), .quo(qa), .ovf(oa));
	bwu_div_lane u_div_b (.clk(clk), .num(ub_s5), .den(ud_s5), .quo(qb), .ovf(ob));
	bwu_div_lane u_div_c (.clk(clk), .num(uc_s5), .den(ud_s5), .quo(qc), .ovf(oc));

	// side band delay line alongside the dividers
	logic [3:0] sb_d_s [0:LAT-1];
	always_ff @(posedge clk) begin
		sb_d_s[0] <= {deg_s5, nga_s5, ngb_s5, ngc_s5};
		for (int i = 1; i < LAT; i++) begin
			sb_d_s[i] <= sb_d_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_out_q <= 1'b0;
			for (int i = 0; i < LAT; i++) begin
				v_d_s[i] <= 1'b0;
			end
		end else begin
			v_s1 <= acc; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4;
			v_d_s[0] <= v_s5;
			for (int i = 1; i < LAT; i++) begin
				v_d_s[i] <= v_d_s[i-1];
			end
			v_out_q <= v_d_s[LAT-1];
		end
	end

	// saturate a magnitude quotient to signed Q16.16
	function automatic logic [bwu_pkg::W_W-1:0] sat_w(
		input logic [bwu_pkg::QUO_W-1:0] q, input logic o, input logic ng);
		logic big;
		big = o || (q[bwu_pkg::QUO_W-1:bwu_pkg::W_W-1] != '0);
		if (ng) begin
			sat_w = big ? bwu_pkg::W_MIN : bwu_pkg::W_W'(-q);
		end else begin
			sat_w = big ? bwu_pkg::W_MAX : bwu_pkg::W_W'(q);
		end
	endfunction

	logic [bwu_pkg::W_W-1:0] wa_q, wb_q, wc_q;
	logic                    deg_q;
	logic [3:0]              sb_end;
	assign sb_end = sb_d_s[LAT-1];

	always_ff @(posedge clk) begin
		deg_q <= sb_end[3] && v_d_s[LAT-1];
		wa_q  <= sb_end[3] ? bwu_pkg::W_NEG_ONE : sat_w(qa, oa, sb_end[2]);
		wb_q  <= sb_end[3] ? bwu_pkg::W_NEG_ONE : sat_w(qb, ob, sb_end[1]);
		wc_q  <= sb_end[3] ? bwu_pkg::W_NEG_ONE : sat_w(qc, oc, sb_end[0]);
	end

	assign done       = v_out_q;
	assign weight_a   = wa_q;
	assign weight_b   = wb_q;
	assign weight_c   = wc_q;
	assign degenerate = deg_q;

	// a flagged beat always carries minus one in every weight
	`BWU_ASSERT_IMP(a_deg_neg_one, clk, arst_n, done && degenerate, (weight_a == bwu_pkg::W_NEG_ONE) && (weight_b == bwu_pkg::W_NEG_ONE) && (weight_c == bwu_pkg::W_NEG_ONE), "degenerate beat without -1.0 weights")
	// the flag never shows outside a result beat
	`BWU_ASSERT_IMP(a_deg_strobe, clk, arst_n, degenerate, done, "degenerate outside a result beat")
	// the last divider stage feeds the output strobe in the next cycle
	`BWU_ASSERT_NXT(a_valid_out, clk, arst_n, v_d_s[LAT-1], done, "result beat lost at output stage")
endmodule
